// File: hdl/wnp_pkg.sv
`default_nettype none
package wnp_pkg;

	localparam int NODES   = 16;
	localparam int NODE_AW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int CNT_W   = $clog2(NODES + 1);

	localparam logic [1:0] CMD_WRITE    = 2'd0;
	localparam logic [1:0] CMD_PICK     = 2'd1;
	localparam logic [1:0] CMD_FEEDBACK = 2'd2;

	localparam logic [1:0] CONG_BUSY     = 2'd1;
	localparam logic [1:0] CONG_OVERLOAD = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_CFG  = 2'd2;

	localparam logic REG_BASE = 1'b0;
	localparam logic REG_MAX  = 1'b1;

	localparam logic [31:0] BASE_RESET = 32'd1;
	localparam logic [31:0] MAX_RESET  = 32'd3600;
	localparam logic [7:0]  FAIL_SAT   = 8'd255;
	localparam logic [7:0]  SHIFT_CAP  = 8'd30;

	typedef struct packed {
		logic [1:0]  command;
		logic [3:0]  node_index;
		logic        enabled;
		logic [15:0] weight;
		logic [1:0]  congestion;
		logic [63:0] now;
		logic [63:0] nonce;
		logic        success;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  pick_slot;
		logic [63:0] retry_at;
		logic [7:0]  fail_total;
	} res_t;

	typedef struct packed {
		logic        enabled;
		logic [15:0] weight;
		logic [1:0]  congestion;
		logic [63:0] retry;
		logic [7:0]  fails;
	} entry_t;

	// effective weight, zero when the node does not take part
	function automatic logic [15:0] eff_weight(input entry_t e, input logic allow_ovl);
		logic [15:0] w;
		w = e.weight;
		if (!e.enabled || w == 16'd0) begin
			w = 16'd0;
		end else if (e.congestion == CONG_OVERLOAD) begin
			w = allow_ovl ? ({3'd0, w[15:3]} + {15'd0, |w[2:0]}) : 16'd0;
		end else if (e.congestion == CONG_BUSY) begin
			w = {1'b0, w[15:1]} + {15'd0, w[0]};
		end
		return w;
	endfunction

endpackage
`default_nettype wire

// File: hdl/wnp_node_ram.sv
`default_nettype none
module wnp_node_ram import wnp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               rd_en,
	input  wire logic [NODE_AW-1:0] rd_addr,
	output entry_t                  rd_data,
	input  wire logic               wr_en,
	input  wire logic [NODE_AW-1:0] wr_addr,
	input  entry_t                  wr_data
);

	entry_t             mem [NODES];
	logic [NODES-1:0]   valid_q;
	entry_t             data_q;
	logic               hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				hit_q <= valid_q[rd_addr];
			end
		end
	end

	// unwritten slots read as zero
	assign rd_data = hit_q ? data_q : '0;

endmodule
`default_nettype wire

// File: hdl/wnp_mod_unit.sv
`default_nettype none
module wnp_mod_unit import wnp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [63:0] divisor,
	output logic             done,
	output logic [63:0]      remainder
);

	logic [63:0] rem_q;
	logic [63:0] dvd_q;
	logic [63:0] dvs_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [64:0] trial;
	logic [64:0] diff;

	assign trial = {rem_q, dvd_q[63]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= diff[64] ? trial[63:0] : diff[63:0];
			dvd_q <= {dvd_q[62:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign remainder = rem_q;

endmodule
`default_nettype wire

// File: hdl/weighted_node_picker_with_backoff.sv
`default_nettype none
// weighted node picker with failure backoff. one request is taken at a time and
// yields one result. a pick walks the 16 slot table up to three times through
// the single read port of the slot memory (one slot a cycle) and runs a bit serial
// 64 bit modulo between the second and third walk; a zero weight sum ends it after
// the second walk. after reset the slot memory reads as all zero at once, so no
// clearing pass is needed. the result sits in an output register until taken;
// configuration is always accepted.
module weighted_node_picker_with_backoff import wnp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  req_t             req,
	output logic             res_valid,
	input  wire logic        res_ready,
	output res_t             res,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE, S_FB_READ, S_FB_WRITE, S_SCAN, S_DIV, S_FINISH
	} state_t;

	state_t              state_q;
	req_t                req_q;
	res_t                res_q;
	logic [31:0]         base_q;
	logic [31:0]         max_q;

	// table walk
	logic [1:0]          pass_q;       // 0 eligibility, 1 sum, 2 select
	logic [CNT_W-1:0]    cnt_q;
	logic                vld_s1;
	logic [NODE_AW-1:0]  idx_s1;
	logic                has_normal_q;
	logic [63:0]         total_q;
	logic [63:0]         ticket_q;

	// feedback
	entry_t              ent_q;
	logic [63:0]         backoff_q;

	// memory ports
	logic                rd_en;
	logic [NODE_AW-1:0]  rd_addr;
	entry_t              rd_data;
	logic                wr_en;
	logic [NODE_AW-1:0]  wr_addr;
	entry_t              wr_data;

	logic                div_start;
	logic                div_done;
	logic [63:0]         div_rem;

	logic                accept;
	logic                in_range;
	logic                cfg_bad;
	logic                node_ready;
	logic [15:0]         w_eff;
	logic [64:0]         sum_wide;
	logic [63:0]         sum_sat;
	logic                last_slot;
	logic                issue;
	logic [7:0]          fail_nx;
	logic [7:0]          shift;
	logic [62:0]         shifted;
	logic [64:0]         retry_wide;
	logic [63:0]         retry_sat;

	assign req_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = req_valid && req_ready;
	assign in_range  = (32'(req.node_index) < NODES);
	assign cfg_bad   = (base_q == 32'd0) || (max_q < base_q);

	// slot read back from the memory during a walk
	assign node_ready = (rd_data.retry <= req_q.now);
	assign w_eff      = node_ready ? eff_weight(rd_data, !has_normal_q) : 16'd0;
	assign sum_wide   = {1'b0, total_q} + {49'd0, w_eff};
	assign sum_sat    = sum_wide[64] ? '1 : sum_wide[63:0];
	assign last_slot  = (idx_s1 == NODE_AW'(NODES - 1));
	assign issue      = (state_q == S_SCAN) && (32'(cnt_q) < NODES);

	// backoff after one more failure
	assign fail_nx = (rd_data.fails == FAIL_SAT) ? FAIL_SAT : rd_data.fails + 8'd1;
	assign shift   = ((fail_nx - 8'd1) > SHIFT_CAP) ? SHIFT_CAP : fail_nx - 8'd1;
	assign shifted = {31'd0, base_q} << shift[4:0];

	assign retry_wide = {1'b0, req_q.now} + {1'b0, backoff_q};
	assign retry_sat  = retry_wide[64] ? '1 : retry_wide[63:0];

	// memory port muxing
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cnt_q[NODE_AW-1:0];
		wr_en   = 1'b0;
		wr_addr = NODE_AW'(req_q.node_index);
		wr_data = ent_q;
		if (accept && req.command == CMD_FEEDBACK && in_range) begin
			rd_en   = 1'b1;
			rd_addr = NODE_AW'(req.node_index);
		end else if (issue) begin
			rd_en = 1'b1;
		end
		if (accept && req.command == CMD_WRITE && in_range) begin
			wr_en   = 1'b1;
			wr_addr = NODE_AW'(req.node_index);
			wr_data = '{enabled: req.enabled, weight: req.weight,
				congestion: req.congestion, retry: req.now, fails: 8'd0};
		end else if (state_q == S_FB_READ && !cfg_bad && req_q.success) begin
			wr_en   = 1'b1;
			wr_data = rd_data;
			wr_data.fails = 8'd0;
			wr_data.retry = req_q.now;
		end else if (state_q == S_FB_WRITE) begin
			wr_en = 1'b1;
			wr_data.retry = retry_sat;
		end
	end

	assign div_start = (state_q == S_SCAN) && vld_s1 && pass_q == 2'd1 && last_slot
		&& sum_sat != 64'd0;

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (state_q == S_FB_READ) begin
			ent_q     <= '{enabled: rd_data.enabled, weight: rd_data.weight,
				congestion: rd_data.congestion, retry: rd_data.retry, fails: fail_nx};
			backoff_q <= ({1'b0, shifted} > {32'd0, max_q}) ? {32'd0, max_q}
				: {1'b0, shifted};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			base_q       <= BASE_RESET;
			max_q        <= MAX_RESET;
			res_valid    <= 1'b0;
			res          <= '0;
			res_q        <= '0;
			pass_q       <= '0;
			cnt_q        <= '0;
			vld_s1       <= 1'b0;
			idx_s1       <= '0;
			has_normal_q <= 1'b0;
			total_q      <= '0;
			ticket_q     <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_BASE) begin
					base_q <= cfg_data;
				end else begin
					max_q <= cfg_data;
				end
			end
			// a result taken while the next one is handed over is reloaded below
			if (res_valid && res_ready && state_q != S_FINISH) begin
				res_valid <= 1'b0;
			end

			// read pipeline of the walk
			vld_s1 <= issue;
			if (issue) begin
				idx_s1 <= cnt_q[NODE_AW-1:0];
				cnt_q  <= cnt_q + CNT_W'(1);
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.command == CMD_PICK) begin
							res_q        <= '0;
							pass_q       <= 2'd0;
							cnt_q        <= '0;
							has_normal_q <= 1'b0;
							total_q      <= '0;
							state_q      <= S_SCAN;
						end else if (req.command == CMD_FEEDBACK && in_range) begin
							res_q   <= '0;
							state_q <= S_FB_READ;
						end else begin
							// write result, or an empty OK result for an unused code or slot
							res_q <= '{status: ST_OK, pick_slot: 4'd0,
								retry_at: (req.command == CMD_WRITE && in_range)
									? req.now : 64'd0,
								fail_total: 8'd0};
							state_q <= S_FINISH;
						end
					end
				end
				S_FB_READ: begin
					if (cfg_bad) begin
						res_q.status     <= ST_CFG;
						res_q.retry_at   <= rd_data.retry;
						res_q.fail_total <= rd_data.fails;
						state_q          <= S_FINISH;
					end else if (req_q.success) begin
						res_q.retry_at <= req_q.now;
						state_q        <= S_FINISH;
					end else begin
						state_q <= S_FB_WRITE;
					end
				end
				S_FB_WRITE: begin
					res_q.retry_at   <= retry_sat;
					res_q.fail_total <= ent_q.fails;
					state_q          <= S_FINISH;
				end
				S_SCAN: begin
					if (vld_s1) begin
						unique case (pass_q)
							2'd0: begin
								if (node_ready && eff_weight(rd_data, 1'b1) != 16'd0
									&& rd_data.congestion != CONG_OVERLOAD) begin
									has_normal_q <= 1'b1;
								end
								if (last_slot) begin
									pass_q <= 2'd1;
									cnt_q  <= '0;
								end
							end
							2'd1: begin
								total_q <= sum_sat;
								if (last_slot) begin
									if (sum_sat == 64'd0) begin
										res_q.status <= ST_NONE;
										state_q      <= S_FINISH;
									end else begin
										state_q <= S_DIV;
									end
								end
							end
							default: begin
								if (w_eff != 16'd0 && ticket_q < {48'd0, w_eff}) begin
									res_q.pick_slot <= 4'(idx_s1);
									state_q         <= S_FINISH;
								end else begin
									if (w_eff != 16'd0) begin
										ticket_q <= ticket_q - {48'd0, w_eff};
									end
									if (last_slot) begin
										res_q.status <= ST_NONE;
										state_q      <= S_FINISH;
									end
								end
							end
						endcase
					end
				end
				S_DIV: begin
					if (div_done) begin
						ticket_q <= div_rem;
						pass_q   <= 2'd2;
						cnt_q    <= '0;
						state_q  <= S_SCAN;
					end
				end
				S_FINISH: begin
					// hand over once the output register is free
					if (!res_valid || res_ready) begin
						res       <= res_q;
						res_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	wnp_node_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	wnp_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (req_q.nonce),
		.divisor   (sum_sat),
		.done      (div_done),
		.remainder (div_rem)
	);

endmodule
`default_nettype wire
